/* rtl/bsll_pkg.sv */
// shared types and constants for the bounded linked list block
`timescale 1ns / 1ps
`default_nettype none
package bsll_pkg;
   localparam int CAPACITY = 64;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;

   localparam logic [2:0] KIND_PUSH_HEAD = 3'd0;
   localparam logic [2:0] KIND_PUSH_TAIL = 3'd1;
   localparam logic [2:0] KIND_INSERT    = 3'd2;
   localparam logic [2:0] KIND_POP_HEAD  = 3'd3;
   localparam logic [2:0] KIND_POP_TAIL  = 3'd4;
   localparam logic [2:0] KIND_DELETE    = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_NOKEY = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_WALK_RD, S_WALK_CHK, S_APPLY, S_LINK_RD, S_LINK_WR,
      S_OUT_RD, S_OUT_SHOW, S_OUT_EMPTY
   } state_type;

   // controller commands to the datapath
   typedef struct packed {
      logic load_req;     // latch the request
      logic walk_start;   // cursor = head, prev = head, step = 0
      logic walk_read;    // read value and link at cursor
      logic walk_adv;     // prev = cursor, cursor = link, step++
      logic apply;        // perform the structural update
      logic link_read;    // read link of the aux node (found node or tail)
      logic link_write;   // second half of update
      logic out_start;    // cursor = head, step = 0
      logic out_load;     // load the output register
      logic out_empty;    // load the empty result
      logic set_status;
      logic [1:0] status;
   } cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic [2:0] kind;
      logic free_zero;
      logic list_zero;
      logic hit;          // value at cursor equals key
      logic step_end;     // step + 1 == list length
      logic rsp_busy;     // output register still holds an item
   } sts_type;
endpackage
`default_nettype wire

/* rtl/bsll_ctrl.sv */
// controller state machine for the bounded linked list
`timescale 1ns / 1ps
`default_nettype none
module bsll_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire bsll_pkg::sts_type  sts,
   output bsll_pkg::cmd_type       cmd
);
   bsll_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= bsll_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsll_pkg::S_IDLE: if (req_valid) state_in = bsll_pkg::S_DECIDE;
         bsll_pkg::S_DECIDE: begin
            case (sts.kind)
               bsll_pkg::KIND_PUSH_HEAD, bsll_pkg::KIND_PUSH_TAIL:
                  state_in = sts.free_zero ? bsll_pkg::S_OUT_RD : bsll_pkg::S_APPLY;
               bsll_pkg::KIND_INSERT:
                  state_in = (sts.free_zero || sts.list_zero) ? bsll_pkg::S_OUT_RD
                                                              : bsll_pkg::S_WALK_RD;
               bsll_pkg::KIND_POP_HEAD, bsll_pkg::KIND_POP_TAIL, bsll_pkg::KIND_DELETE:
                  state_in = sts.list_zero ? bsll_pkg::S_OUT_RD : bsll_pkg::S_WALK_RD;
               default: state_in = bsll_pkg::S_OUT_RD;
            endcase
         end
         bsll_pkg::S_WALK_RD: state_in = bsll_pkg::S_WALK_CHK;
         bsll_pkg::S_WALK_CHK: begin
            if (sts.kind == bsll_pkg::KIND_POP_TAIL) begin
               state_in = sts.step_end ? bsll_pkg::S_APPLY : bsll_pkg::S_WALK_RD;
            end else if (sts.kind == bsll_pkg::KIND_POP_HEAD) begin
               // head node and its link have been read
               state_in = bsll_pkg::S_APPLY;
            end else if (sts.hit) begin
               state_in = bsll_pkg::S_APPLY;
            end else begin
               state_in = sts.step_end ? bsll_pkg::S_OUT_RD : bsll_pkg::S_WALK_RD;
            end
         end
         bsll_pkg::S_APPLY: state_in = bsll_pkg::S_LINK_RD;
         bsll_pkg::S_LINK_RD: state_in = bsll_pkg::S_LINK_WR;
         bsll_pkg::S_LINK_WR: state_in = bsll_pkg::S_OUT_RD;
         bsll_pkg::S_OUT_RD: begin
            if (!sts.rsp_busy)
               state_in = sts.list_zero ? bsll_pkg::S_OUT_EMPTY : bsll_pkg::S_OUT_SHOW;
         end
         bsll_pkg::S_OUT_SHOW: begin
            if (!sts.rsp_busy)
               state_in = sts.step_end ? bsll_pkg::S_IDLE : bsll_pkg::S_OUT_RD;
         end
         bsll_pkg::S_OUT_EMPTY: if (!sts.rsp_busy) state_in = bsll_pkg::S_IDLE;
         default: state_in = bsll_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      req_stall = (state_ff != bsll_pkg::S_IDLE);
      case (state_ff)
         bsll_pkg::S_IDLE: cmd.load_req = req_valid;
         bsll_pkg::S_DECIDE: begin
            cmd.walk_start = 1'b1;
            cmd.set_status = 1'b1;
            case (sts.kind)
               bsll_pkg::KIND_PUSH_HEAD, bsll_pkg::KIND_PUSH_TAIL:
                  cmd.status = sts.free_zero ? bsll_pkg::ST_FULL : bsll_pkg::ST_OK;
               bsll_pkg::KIND_INSERT:
                  cmd.status = sts.free_zero ? bsll_pkg::ST_FULL :
                               (sts.list_zero ? bsll_pkg::ST_NOKEY : bsll_pkg::ST_OK);
               bsll_pkg::KIND_POP_HEAD, bsll_pkg::KIND_POP_TAIL, bsll_pkg::KIND_DELETE:
                  cmd.status = sts.list_zero ? bsll_pkg::ST_EMPTY : bsll_pkg::ST_OK;
               default: cmd.status = bsll_pkg::ST_OK;
            endcase
         end
         bsll_pkg::S_WALK_RD: cmd.walk_read = 1'b1;
         bsll_pkg::S_WALK_CHK: begin
            if (sts.kind == bsll_pkg::KIND_POP_TAIL) begin
               cmd.walk_adv = !sts.step_end;
            end else if (sts.kind != bsll_pkg::KIND_POP_HEAD && !sts.hit) begin
               cmd.walk_adv = !sts.step_end;
               cmd.set_status = sts.step_end;
               cmd.status = bsll_pkg::ST_NOKEY;
            end
         end
         bsll_pkg::S_APPLY: cmd.apply = 1'b1;
         bsll_pkg::S_LINK_RD: cmd.link_read = 1'b1;
         bsll_pkg::S_LINK_WR: begin
            cmd.link_write = 1'b1;
            cmd.out_start = 1'b1;
         end
         bsll_pkg::S_OUT_RD: cmd.walk_read = !sts.rsp_busy;
         bsll_pkg::S_OUT_SHOW: begin
            cmd.out_load = !sts.rsp_busy;
         end
         bsll_pkg::S_OUT_EMPTY: cmd.out_empty = !sts.rsp_busy;
         default: ;
      endcase
      // status-only paths go straight to listing
      if (state_in == bsll_pkg::S_OUT_RD && state_ff != bsll_pkg::S_OUT_RD &&
          state_ff != bsll_pkg::S_OUT_SHOW && state_ff != bsll_pkg::S_LINK_WR)
         cmd.out_start = 1'b1;
   end
endmodule
`default_nettype wire

/* rtl/bsll_datapath.sv */
// node pool, free stack, list pointers and output register
`timescale 1ns / 1ps
`default_nettype none
module bsll_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bsll_pkg::cmd_type  cmd,
   output bsll_pkg::sts_type       sts,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_key,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_element_valid,
   output logic signed [31:0]      rsp_element,
   output logic                    rsp_last
);
   localparam int IW = bsll_pkg::IDX_W;
   localparam int CW = bsll_pkg::CNT_W;

   // memories
   logic [31:0]   val_mem  [bsll_pkg::CAPACITY];
   logic [IW-1:0] link_mem [bsll_pkg::CAPACITY];
   logic [IW-1:0] free_mem [bsll_pkg::CAPACITY];

   logic [2:0]    kind_ff;
   logic [31:0]   value_ff, key_ff;
   logic [1:0]    status_ff;
   logic [IW-1:0] head_ff, tail_ff, cur_ff, prev_ff, node_ff, aux_ff;
   logic [CW-1:0] len_ff, free_ff, step_ff, wipe_ff;
   logic [31:0]   rd_val_ff;
   logic [IW-1:0] rd_link_ff, free_rd_ff;
   logic          rsp_valid_ff;

   // free stack read address
   logic [CW-1:0] free_dec;
   assign free_dec = free_ff - 1'b1;

   // pending write port to the free stack (reset init sweep or give back)
   logic          free_we;
   logic [IW-1:0] free_wa, free_wd;
   logic          wiping;
   assign wiping = (wipe_ff != CW'(bsll_pkg::CAPACITY));

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         value_ff <= req_value;
         key_ff <= req_key;
      end
      if (cmd.set_status) status_ff <= cmd.status;
   end

   // free stack initialisation sweep after reset
   always_ff @(posedge clock) begin
      if (reset) wipe_ff <= '0;
      else if (wiping) wipe_ff <= wipe_ff + 1'b1;
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (free_we) free_mem[free_wa] <= free_wd;
      free_rd_ff <= free_mem[free_dec[IW-1:0]];
   end

   // node memories with registered reads at the cursor or the aux node
   logic          val_we, link_we;
   logic [IW-1:0] val_wa, link_wa, link_wd, rd_addr;
   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= value_ff;
      if (link_we) link_mem[link_wa] <= link_wd;
      rd_val_ff <= val_mem[rd_addr];
      rd_link_ff <= link_mem[rd_addr];
   end

   logic pop_one;
   assign pop_one = (len_ff == CW'(1));

   // structural update
   always_comb begin
      free_we = wiping;
      free_wa = wipe_ff[IW-1:0];
      free_wd = wipe_ff[IW-1:0];
      val_we = 1'b0;
      val_wa = free_rd_ff;
      link_we = 1'b0;
      link_wa = node_ff;
      link_wd = '0;
      rd_addr = cmd.link_read ? aux_ff : cur_ff;
      if (cmd.apply && status_ff == bsll_pkg::ST_OK) begin
         case (kind_ff)
            bsll_pkg::KIND_PUSH_HEAD, bsll_pkg::KIND_PUSH_TAIL,
            bsll_pkg::KIND_INSERT: begin
               val_we = 1'b1;
               link_we = 1'b1;
               link_wa = free_rd_ff;
               // insert: new node takes the found node's link, still held from the walk
               if (kind_ff == bsll_pkg::KIND_PUSH_HEAD) link_wd = head_ff;
               else if (kind_ff == bsll_pkg::KIND_INSERT) link_wd = rd_link_ff;
               else link_wd = '0;
            end
            default: begin
               free_we = 1'b1;
               free_wa = free_ff[IW-1:0];
               free_wd = (kind_ff == bsll_pkg::KIND_POP_HEAD) ? head_ff : cur_ff;
            end
         endcase
      end
      if (cmd.link_write && status_ff == bsll_pkg::ST_OK) begin
         case (kind_ff)
            bsll_pkg::KIND_PUSH_TAIL: begin
               link_we = !pop_one;
               link_wa = aux_ff;
               link_wd = node_ff;
            end
            bsll_pkg::KIND_INSERT: begin
               // found node points to the new node
               link_we = 1'b1;
               link_wa = aux_ff;
               link_wd = node_ff;
            end
            bsll_pkg::KIND_POP_TAIL, bsll_pkg::KIND_DELETE: begin
               link_we = !pop_one && (aux_ff != head_ff) && (node_ff != head_ff);
               link_wa = prev_ff;
               link_wd = rd_link_ff;
            end
            default: ;
         endcase
      end
   end

   // pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         len_ff <= '0;
         free_ff <= CW'(bsll_pkg::CAPACITY);
      end else begin
         if (cmd.apply && status_ff == bsll_pkg::ST_OK) begin
            case (kind_ff)
               bsll_pkg::KIND_PUSH_HEAD, bsll_pkg::KIND_PUSH_TAIL,
               bsll_pkg::KIND_INSERT: begin
                  free_ff <= free_dec;
                  len_ff <= len_ff + 1'b1;
                  if (len_ff == '0) begin
                     head_ff <= free_rd_ff;
                     tail_ff <= free_rd_ff;
                  end else if (kind_ff == bsll_pkg::KIND_PUSH_HEAD) begin
                     head_ff <= free_rd_ff;
                  end else if (kind_ff == bsll_pkg::KIND_PUSH_TAIL) begin
                     tail_ff <= free_rd_ff;
                  end else if (cur_ff == tail_ff) begin
                     tail_ff <= free_rd_ff;
                  end
               end
               default: begin
                  free_ff <= free_ff + 1'b1;
                  len_ff <= len_ff - 1'b1;
                  if (pop_one) begin
                     head_ff <= '0;
                     tail_ff <= '0;
                  end else if (kind_ff == bsll_pkg::KIND_POP_HEAD || cur_ff == head_ff) begin
                     head_ff <= rd_link_ff;
                  end else if (cur_ff == tail_ff) begin
                     tail_ff <= prev_ff;
                  end
               end
            endcase
         end
      end
   end

   // cursor and scratch indexes
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         cur_ff <= head_ff;
         prev_ff <= head_ff;
         step_ff <= '0;
      end
      if (cmd.walk_adv) begin
         prev_ff <= cur_ff;
         cur_ff <= rd_link_ff;
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.apply) begin
         node_ff <= free_rd_ff;
         // aux: node whose link is read or written next
         case (kind_ff)
            bsll_pkg::KIND_PUSH_TAIL: aux_ff <= tail_ff;
            bsll_pkg::KIND_INSERT:    aux_ff <= cur_ff;
            default:                  aux_ff <= cur_ff;
         endcase
         if (kind_ff == bsll_pkg::KIND_POP_TAIL || kind_ff == bsll_pkg::KIND_DELETE)
            node_ff <= cur_ff;
      end
      if (cmd.out_start) begin
         cur_ff <= head_ff;
         step_ff <= '0;
      end
      if (cmd.out_load) begin
         cur_ff <= rd_link_ff;
         step_ff <= step_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load || cmd.out_empty) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load || cmd.out_empty) begin
         rsp_status <= status_ff;
         rsp_element_valid <= cmd.out_load;
         rsp_element <= cmd.out_load ? rd_val_ff : '0;
         rsp_last <= cmd.out_empty || (step_ff + 1'b1 == len_ff);
      end
   end
   assign rsp_valid = rsp_valid_ff;

   // status to the controller
   always_comb begin
      sts.kind = kind_ff;
      sts.free_zero = (free_ff == '0);
      sts.list_zero = (len_ff == '0);
      sts.hit = (rd_val_ff == key_ff);
      sts.step_end = (step_ff + 1'b1 == len_ff);
      sts.rsp_busy = rsp_valid_ff && rsp_stall;
   end
endmodule
`default_nettype wire

/* rtl/bounded_singly_linked_list.sv */
// top level of the bounded linked list block
`timescale 1ns / 1ps
`default_nettype none
// Keeps a list of signed 32-bit values in a 64-node pool with next links and a
// free stack. One operation is taken at a time: push head/tail, insert after
// key, pop head/tail, delete key. A walk for a key or the tail visits each node
// with a registered read of the node memory followed by a compare; pop head
// reads the head node the same way. The update passes through the apply, link
// read and link write states, and the listing then emits one item per entry
// (one item with element_valid low for an empty list), each read and then
// shown, waiting while the receiver stalls. After reset the free stack is filled
// and requests are stalled until it is full.
module bounded_singly_linked_list (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_key,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_element_valid,
   output logic signed [31:0]      rsp_element,
   output logic                    rsp_last
);
   bsll_pkg::cmd_type cmd;
   bsll_pkg::sts_type sts;
   logic              ctrl_stall;
   logic [6:0]        boot_ff;

   // hold off requests while the free stack is filled
   always_ff @(posedge clock) begin
      if (reset) boot_ff <= '0;
      else if (boot_ff != 7'(bsll_pkg::CAPACITY)) boot_ff <= boot_ff + 1'b1;
   end
   assign req_stall = ctrl_stall || (boot_ff != 7'(bsll_pkg::CAPACITY));

   bsll_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid && (boot_ff == 7'(bsll_pkg::CAPACITY))),
      .req_stall(ctrl_stall), .sts(sts), .cmd(cmd)
   );

   bsll_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_kind(req_kind), .req_value(req_value), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_element_valid(rsp_element_valid), .rsp_element(rsp_element),
      .rsp_last(rsp_last)
   );

   // an empty-list item is always the last one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_element_valid) |-> rsp_last)
      else $error("empty item without last");

   // no request is taken while the controller is busy
   assert property (@(posedge clock) disable iff (reset)
      ctrl_stall |-> !cmd.load_req)
      else $error("request loaded while busy");

   // output is never overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(cmd.out_load || cmd.out_empty))
      else $error("output overwritten");
endmodule
`default_nettype wire

/* test/bsll_checker.sv */
// checker: predicts the listing of the linked list block and compares result items
`timescale 1ns / 1ps
module bsll_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_key,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_status,
   input  wire logic               rsp_element_valid,
   input  wire logic signed [31:0] rsp_element,
   input  wire logic               rsp_last,
   output int                      fail_count,
   output int                      pending,
   output int                      list_size
);
   typedef struct packed {
      logic [1:0]         status;
      logic               element_valid;
      logic signed [31:0] element;
      logic               last;
   } listing_type;

   // the list itself, head first
   logic signed [31:0] entries[$];
   listing_type        listing_q[$];

   assign pending   = listing_q.size();
   assign list_size = entries.size();

   function automatic int find_first(logic signed [31:0] key);
      foreach (entries[i]) if (entries[i] == key) return i;
      return -1;
   endfunction

   // apply one operation and queue the listing that follows it
   task automatic predict_listing(logic [2:0] kind, logic signed [31:0] value,
                                  logic signed [31:0] key);
      logic [1:0]  status;
      int          pos;
      listing_type item;
      status = bsll_pkg::ST_OK;
      pos = find_first(key);
      case (kind)
         bsll_pkg::KIND_PUSH_HEAD: begin
            if (entries.size() == bsll_pkg::CAPACITY) status = bsll_pkg::ST_FULL;
            else entries.push_front(value);
         end
         bsll_pkg::KIND_PUSH_TAIL: begin
            if (entries.size() == bsll_pkg::CAPACITY) status = bsll_pkg::ST_FULL;
            else entries.push_back(value);
         end
         bsll_pkg::KIND_INSERT: begin
            if (entries.size() == bsll_pkg::CAPACITY) status = bsll_pkg::ST_FULL;
            else if (pos < 0) status = bsll_pkg::ST_NOKEY;
            else entries.insert(pos + 1, value);
         end
         bsll_pkg::KIND_POP_HEAD: begin
            if (entries.size() == 0) status = bsll_pkg::ST_EMPTY;
            else void'(entries.pop_front());
         end
         bsll_pkg::KIND_POP_TAIL: begin
            if (entries.size() == 0) status = bsll_pkg::ST_EMPTY;
            else void'(entries.pop_back());
         end
         bsll_pkg::KIND_DELETE: begin
            if (entries.size() == 0) status = bsll_pkg::ST_EMPTY;
            else if (pos < 0) status = bsll_pkg::ST_NOKEY;
            else entries.delete(pos);
         end
         default: ;
      endcase
      if (entries.size() == 0) begin
         item = '{status, 1'b0, 32'sd0, 1'b1};
         listing_q.push_back(item);
      end else begin
         foreach (entries[i]) begin
            item = '{status, 1'b1, entries[i], i == entries.size() - 1};
            listing_q.push_back(item);
         end
      end
   endtask

   // watch both channels
   always @(posedge clock) begin
      listing_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) predict_listing(req_kind, req_value, req_key);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_element_valid, rsp_element, rsp_last};
            if (listing_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result item %p", got);
            end else begin
               want = listing_q.pop_front();
               if (want !== got) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, got);
               end
            end
         end
      end
   end
endmodule

/* test/tb_top.sv */
// testbench top: drives operations into the linked list block and gives the verdict
`timescale 1ns / 1ps
module tb_top;
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_kind;
   logic signed [31:0] req_value;
   logic signed [31:0] req_key;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic               rsp_element_valid;
   logic signed [31:0] rsp_element;
   logic               rsp_last;
   int                 fail_count, pending, list_size;
   int                 idle_count;
   int                 op_count;
   bit                 quiet_phase;
   bit                 hold_rsp;
   logic signed [31:0] known[$];

   bounded_singly_linked_list u_top (.*);

   bsll_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count > 20000) begin
         $display("timeout with %0d result items outstanding", pending);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // receiver stalls in bursts, plus long hold-offs when asked
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            for (n = 0; n < 3000; n++) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            n = $urandom_range(1, 14);
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            n = $urandom_range(1, 20);
            repeat (n) @(negedge clock);
         end
      end
   end

   // offer one operation and wait for it to be taken; valid stays up
   // with the old payload until the next offer or an explicit idle
   task automatic send_op(logic [2:0] kind, logic signed [31:0] value,
                          logic signed [31:0] key);
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (kind <= bsll_pkg::KIND_INSERT) known.push_back(value);
      op_count++;
   endtask

   // drop the offer
   task automatic idle_req();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_key();
      if (known.size() > 0 && $urandom_range(0, 4) != 0)
         return known[$urandom_range(0, known.size() - 1)];
      return $urandom();
   endfunction

   initial begin
      int i;
      logic [2:0] kind;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = '0;
      req_value = '0;
      req_key = '0;
      quiet_phase = 1'b0;
      hold_rsp = 1'b0;
      op_count = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: empty cases, extremes, head and tail handling
      send_op(bsll_pkg::KIND_POP_HEAD, 0, 0);
      send_op(bsll_pkg::KIND_POP_TAIL, 0, 0);
      send_op(bsll_pkg::KIND_DELETE, 0, 5);
      send_op(bsll_pkg::KIND_INSERT, 1, 5);
      send_op(bsll_pkg::KIND_PUSH_TAIL, 32'sh7fffffff, 0);
      send_op(bsll_pkg::KIND_POP_TAIL, 0, 0);
      send_op(bsll_pkg::KIND_PUSH_HEAD, 32'sh80000000, 0);
      send_op(bsll_pkg::KIND_POP_HEAD, 0, 0);
      send_op(bsll_pkg::KIND_PUSH_HEAD, -1, 0);
      send_op(bsll_pkg::KIND_PUSH_TAIL, 7, 0);
      send_op(bsll_pkg::KIND_INSERT, 32'sh55555555, 7);
      send_op(bsll_pkg::KIND_INSERT, 32'shaaaaaaaa, -1);
      send_op(bsll_pkg::KIND_DELETE, 0, 123);
      send_op(bsll_pkg::KIND_INSERT, 9, 123);
      send_op(bsll_pkg::KIND_DELETE, 0, -1);
      send_op(bsll_pkg::KIND_DELETE, 0, 32'sh55555555);
      send_op(3'd6, 0, 0);
      send_op(3'd7, -1, -1);
      send_op(bsll_pkg::KIND_DELETE, 0, 32'shaaaaaaaa);
      send_op(bsll_pkg::KIND_DELETE, 0, 7);

      // fill the pool to full, with a long receiver hold-off on the way
      hold_rsp = 1'b1;
      while (list_size < bsll_pkg::CAPACITY || pending > 0) begin
         if (list_size + pending < bsll_pkg::CAPACITY * 2 || pending == 0)
            send_op(($urandom_range(0, 1) != 0) ? bsll_pkg::KIND_PUSH_HEAD
                                                : bsll_pkg::KIND_PUSH_TAIL,
                    $urandom(), 0);
         else idle_req();
         if (op_count > 400) break;
      end
      send_op(bsll_pkg::KIND_PUSH_HEAD, 1, 0);
      send_op(bsll_pkg::KIND_INSERT, 2, pick_key());

      // random operations, biased to keep the list mid-sized
      for (i = 0; i < 480; i++) begin
         if (i == 400) quiet_phase = 1'b1;
         if ($urandom_range(0, 9) == 0) kind = 3'($urandom_range(0, 7));
         else if (list_size < 10) kind = 3'($urandom_range(0, 2));
         else if (list_size > 40) kind = 3'($urandom_range(2, 5));
         else kind = 3'($urandom_range(0, 5));
         send_op(kind, $urandom(), pick_key());
      end

      req_valid <= 1'b0;
      while (pending > 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("ran %0d operations, all six kinds and unused codes, pool full and empty",
               op_count);
      if (fail_count == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end
endmodule
